### hdl/linear_interp_resampler_defines.svh
// assertion macros for the resampler rtl (used by lir_back)
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LIR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lir_pkg.sv
package lir_pkg;

    localparam int RATIO_W     = 24;
    localparam int MAX_RESULTS = 64;
    localparam int QUEUE_DEPTH = 2;

endpackage

### hdl/lir_front.sv
module lir_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                          i_end_of_stream,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [2*SAMPLE_BITS:0]        o_job
);

    logic                          r_have;
    logic                          r_fresh;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic                          accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    // a beat with a held sample becomes a job: {fresh, y1, y2}
    assign o_push  = accept && r_have;
    assign o_job   = {r_fresh, r_prev, i_sample_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_fresh <= 1'b0;
            r_prev  <= '0;
        end else if (accept) begin
            if (i_end_of_stream) begin
                r_have  <= 1'b0;
                r_fresh <= 1'b0;
                r_prev  <= '0;
            end else if (!r_have) begin
                r_have  <= 1'b1;
                r_fresh <= 1'b1;
                r_prev  <= i_sample_value;
            end else begin
                r_fresh <= 1'b0;
                r_prev  <= i_sample_value;
            end
        end
    end

endmodule

### hdl/lir_queue.sv
module lir_queue #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/lir_back.sv
`include "linear_interp_resampler_defines.svh"

module lir_back #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lir_pkg::RATIO_W-1:0]   i_step,
    input  logic                          i_job_valid,
    input  logic [2*SAMPLE_BITS:0]        i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_resampled_value,
    output logic                          o_last_in_run
);

    localparam int RW       = lir_pkg::RATIO_W;
    localparam int POS_W    = ((FRACTION_BITS > RW) ? FRACTION_BITS : RW) + 1;
    localparam int DW       = SAMPLE_BITS + 1;
    localparam int PW       = DW + FRACTION_BITS + 1;
    localparam int MIN_STEP = (1 << FRACTION_BITS) / lir_pkg::MAX_RESULTS;
    localparam logic [POS_W-1:0] ONE = POS_W'(1) << FRACTION_BITS;

    logic                          j_fresh;
    logic signed [SAMPLE_BITS-1:0] j_y1;
    logic signed [SAMPLE_BITS-1:0] j_y2;
    logic [RW-1:0]                 step_clamped;
    logic [POS_W-1:0]              step_eff;
    logic [POS_W-1:0]              pos_next;
    logic                          at_end;
    logic                          load;
    logic                          issue;
    logic                          issue_last;
    logic                          m_ready;
    logic                          o_free;
    logic signed [PW-1:0]          sum_full;

    logic                          r_busy;
    logic [POS_W-1:0]              r_pos;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [DW-1:0]          r_diff;

    logic                          r_m_valid;
    logic signed [PW-1:0]          r_prod;
    logic signed [SAMPLE_BITS-1:0] r_m_y1;
    logic                          r_m_last;

    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_value;
    logic                          r_o_last;

    assign j_fresh = i_job[2*SAMPLE_BITS];
    assign j_y1    = i_job[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign j_y2    = i_job[SAMPLE_BITS-1:0];

    assign step_clamped = (i_step < RW'(MIN_STEP)) ? RW'(MIN_STEP) : i_step;
    assign step_eff     = POS_W'(step_clamped);
    assign pos_next     = r_pos + step_eff;
    assign at_end       = (r_pos >= ONE);

    assign o_free     = !r_o_valid || i_ready;
    assign m_ready    = !r_m_valid || o_free;
    assign load       = !r_busy && i_job_valid;
    assign issue      = r_busy && !at_end && m_ready;
    assign issue_last = (pos_next >= ONE);
    assign o_pop      = load;

    // sequencer: one position per cycle, while the multiply stage can take it, until the position reaches 1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_y1   <= j_y1;
            r_diff <= DW'(j_y2) - DW'(j_y1);
            if (j_fresh) begin
                r_pos <= '0;
            end
        end else if (r_busy && at_end) begin
            r_busy <= 1'b0;
            r_pos  <= r_pos - ONE;
        end else if (issue) begin
            r_pos <= pos_next;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            if (m_ready) begin
                r_m_valid <= issue;
            end
            if (issue) begin
                r_prod   <= r_diff * $signed({1'b0, r_pos[FRACTION_BITS-1:0]});
                r_m_y1   <= r_y1;
                r_m_last <= issue_last;
            end
        end
    end

    // floor of the scaled product, then add to y1
    assign sum_full = PW'(r_m_y1) + (r_prod >>> FRACTION_BITS);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (o_free) begin
                r_o_valid <= r_m_valid;
            end
            if (o_free && r_m_valid) begin
                r_o_value <= sum_full[SAMPLE_BITS-1:0];
                r_o_last  <= r_m_last;
            end
        end
    end

    assign o_valid           = r_o_valid;
    assign o_resampled_value = r_o_value;
    assign o_last_in_run     = r_o_last;

    `LIR_ASSERT_NEXT(a_last_closes_run, i_clk, i_rst_n, issue && issue_last,
        r_busy && at_end, "last beat did not close the run")
    `LIR_ASSERT_NEXT(a_mid_keeps_run, i_clk, i_rst_n, issue && !issue_last,
        r_busy && !at_end, "run ended without a last beat")
    `LIR_ASSERT_NEXT(a_fresh_start, i_clk, i_rst_n, load && j_fresh,
        r_pos == '0, "stream start did not clear the position")
    `LIR_ASSERT_SAME(a_no_load_busy, i_clk, i_rst_n, r_busy && !at_end,
        !o_pop, "job popped while a run is in progress")

endmodule

### hdl/linear_interp_resampler.sv
// linear interpolation resampler
// input channel: i_valid / o_ready carry one sample per beat, with
// i_end_of_stream on the final sample of a stream. output channel:
// o_valid / i_ready carry interpolated samples, o_last_in_run marking the
// last output caused by one input sample.
// i_cfg_we / i_cfg_data write the output-to-input period ratio (8.16 fixed
// point); write it only while the block is idle.
// the first sample of a stream gives no output. each later sample gives
// the outputs whose positions fall between it and the sample before.
// the first output of a sample passes the job queue, the sequencer, the
// multiply stage and the output register. throughput: one output per cycle
// while a sample's run lasts and i_ready holds; a job waits for the run's end.
// a 2-entry job queue lets the input side keep accepting during a run.
// reset clears the stream control state and sets the ratio to 1.0.
// a stalled receiver holds the output register, then the multiply stage,
// then the sequencer; the input side stalls once the job queue is full.
module linear_interp_resampler #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lir_pkg::RATIO_W-1:0]          i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_value,
    input  logic                                 i_end_of_stream,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [SAMPLE_BITS-1:0]        o_resampled_value,
    output logic                                 o_last_in_run
);

    localparam int RW    = lir_pkg::RATIO_W;
    localparam int JOB_W = 2 * SAMPLE_BITS + 1;
    localparam logic [RW-1:0] RESET_RATIO = RW'(64'd1 << FRACTION_BITS);

    logic [RW-1:0]    r_step_ratio;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [JOB_W-1:0] q_in;
    logic [JOB_W-1:0] q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ratio <= RESET_RATIO;
        end else if (i_cfg_we) begin
            r_step_ratio <= i_cfg_data;
        end
    end

    lir_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_value (i_sample_value),
        .i_end_of_stream(i_end_of_stream),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_job          (q_in)
    );

    lir_queue #(
        .WIDTH(JOB_W),
        .DEPTH(lir_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    lir_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (r_step_ratio),
        .i_job_valid      (!q_empty),
        .i_job            (q_out),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_resampled_value(o_resampled_value),
        .o_last_in_run    (o_last_in_run)
    );

endmodule
